@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks used by byte_exp_xor_mix_core; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check while out of reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");
// check that also covers reset cycles
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ rtl/bexm_pkg.sv @@
// ----------------------------------------------------------------------------
// bexm_pkg
// Shared widths, lane control type and the exp/log byte tables
// (exp(v) = 45^v mod 257, with 256 stored as 0; log is its inverse).
// ----------------------------------------------------------------------------
`default_nettype none

package bexm_pkg;

    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 64;
    localparam int MAX_LANES = WORD_W / BYTE_W;
    localparam int LANES_DEF = 8;
    localparam int ROM_DEPTH = 256;
    localparam int EXP_BASE  = 45;
    localparam int EXP_MOD   = 257;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef t_byte t_rom [ROM_DEPTH];

    typedef struct packed {
        logic load;
        logic inverse;
    } t_lane_ctl;

    // elaboration-time table builders
    function automatic t_rom build_exp();
        t_rom rom;
        int   v;
        v = 1;
        for (int i = 0; i < ROM_DEPTH; i++) begin
            rom[i] = (v == ROM_DEPTH) ? '0 : t_byte'(v);
            v = (v * EXP_BASE) % EXP_MOD;
        end
        return rom;
    endfunction

    function automatic t_rom build_log();
        t_rom rom;
        int   v;
        v = 1;
        for (int i = 0; i < ROM_DEPTH; i++) begin
            rom[(v == ROM_DEPTH) ? 0 : v] = t_byte'(i);
            v = (v * EXP_BASE) % EXP_MOD;
        end
        return rom;
    endfunction

    localparam t_rom EXP_ROM = build_exp();
    localparam t_rom LOG_ROM = build_log();

endpackage

`default_nettype wire

@@ rtl/bexm_lane.sv @@
// ----------------------------------------------------------------------------
// bexm_lane
// One byte lane: exp lookups are registered, then xor and optional log.
// ----------------------------------------------------------------------------
`default_nettype none

module bexm_lane (
    input  wire logic                 i_clk,
    input  wire bexm_pkg::t_lane_ctl  i_ctl,
    input  wire bexm_pkg::t_byte      i_x_byte,
    input  wire bexm_pkg::t_byte      i_c_byte,
    output bexm_pkg::t_byte           o_byte
);

    bexm_pkg::t_byte r_ex;
    bexm_pkg::t_byte r_ec;
    bexm_pkg::t_byte r_x;
    logic            r_inv;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_ex  <= bexm_pkg::EXP_ROM[i_x_byte];
            r_ec  <= bexm_pkg::EXP_ROM[i_c_byte];
            r_x   <= i_x_byte;
            r_inv <= i_ctl.inverse;
        end
    end

    always_comb begin
        if (r_inv) begin
            o_byte = bexm_pkg::LOG_ROM[r_x ^ r_ec];
        end else begin
            o_byte = r_ex ^ r_ec;
        end
    end

endmodule

`default_nettype wire

@@ rtl/bexm_merge.sv @@
// ----------------------------------------------------------------------------
// bexm_merge
// Packs the lane bytes into the result word and registers it with its strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module bexm_merge #(
    parameter int LANES = bexm_pkg::LANES_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_vld,
    input  wire logic [LANES-1:0][bexm_pkg::BYTE_W-1:0] i_lane_bytes,
    output logic                                       o_valid,
    output logic [bexm_pkg::WORD_W-1:0]                o_word
);

    logic [bexm_pkg::WORD_W-1:0] n_word;
    logic [bexm_pkg::WORD_W-1:0] r_word;
    logic                        r_valid;

    // lane zero lands in the highest byte in use; bytes above stay zero
    always_comb begin
        n_word = '0;
        for (int k = 0; k < LANES; k++) begin
            n_word[(LANES-1-k)*bexm_pkg::BYTE_W +: bexm_pkg::BYTE_W] = i_lane_bytes[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire

@@ rtl/byte_exp_xor_mix_core.sv @@
// ----------------------------------------------------------------------------
// byte_exp_xor_mix_core
// Bytewise exp/xor mixer with log inverse, one lane per operand byte.
// ----------------------------------------------------------------------------
// Timing: an accepted start loads the lane registers, then the merge register
// captures the result word and raises the strobe.
// Throughput: one item per cycle once busy is low; lane exp lookups, then
// xor/log and the merge register form a two-stage pipeline with no stall path.
// Reset: synchronous, active low; clears the strobe pipeline. busy is high
// during reset and through the first edge that samples reset released.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module byte_exp_xor_mix_core #(
    parameter int LANES = bexm_pkg::LANES_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        i_action,
    input  wire logic [bexm_pkg::WORD_W-1:0] i_operand_x,
    input  wire logic [bexm_pkg::WORD_W-1:0] i_operand_c,
    output logic                             o_valid,
    output logic [bexm_pkg::WORD_W-1:0]      o_result_word
);

    logic                                  accept;
    logic                                  r_up;
    logic                                  r_vld1;
    bexm_pkg::t_lane_ctl                   lane_ctl;
    logic [LANES-1:0][bexm_pkg::BYTE_W-1:0] lane_bytes;

    assign busy     = ~r_up;
    assign accept   = start & ~busy;
    assign lane_ctl = '{load: accept, inverse: i_action};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up   <= 1'b0;
            r_vld1 <= 1'b0;
        end else begin
            r_up   <= 1'b1;
            r_vld1 <= accept;
        end
    end

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        bexm_lane u_lane (
            .i_clk    (i_clk),
            .i_ctl    (lane_ctl),
            .i_x_byte (i_operand_x[(LANES-1-k)*bexm_pkg::BYTE_W +: bexm_pkg::BYTE_W]),
            .i_c_byte (i_operand_c[(LANES-1-k)*bexm_pkg::BYTE_W +: bexm_pkg::BYTE_W]),
            .o_byte   (lane_bytes[k])
        );
    end

    bexm_merge #(
        .LANES (LANES)
    ) u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vld        (r_vld1),
        .i_lane_bytes (lane_bytes),
        .o_valid      (o_valid),
        .o_word       (o_result_word)
    );

    `ASSERT_CLK(a_accept_gives_result, i_clk, i_rst_n, accept |-> ##2 o_valid)
    `ASSERT_CLK(a_result_has_item, i_clk, i_rst_n, o_valid |-> $past(accept, 2))
    `ASSERT_ALWAYS(a_reset_clears_strobe, i_clk, !i_rst_n |=> !o_valid)
    `ASSERT_ALWAYS(a_ready_after_reset, i_clk, (i_rst_n && $past(i_rst_n)) |-> !busy)

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for byte_exp_xor_mix_core. A queue-fed driver offers
// forward and inverse items with random gaps. A monitor compares every strobed
// result word against a byte-lane exp/log predictor built from its own tables.
// ----------------------------------------------------------------------------

module tb_top;

    localparam int    NUM_LANES  = bexm_pkg::LANES_DEF;
    localparam int    GEN_BASE   = 45;
    localparam int    GEN_MOD    = 257;
    localparam int    WRAP_VALUE = 256;
    localparam int    PIPE_LAT   = 2;
    localparam int    PHASE_ITEMS = 450;
    localparam logic  ACT_FWD    = 1'b0;
    localparam logic  ACT_INV    = 1'b1;

    typedef struct packed {
        logic                        action;
        logic [bexm_pkg::WORD_W-1:0] x;
        logic [bexm_pkg::WORD_W-1:0] c;
    } t_mix_item;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic                        i_action = 1'b0;
    logic [bexm_pkg::WORD_W-1:0] i_operand_x = '0;
    logic [bexm_pkg::WORD_W-1:0] i_operand_c = '0;
    logic                        o_valid;
    logic [bexm_pkg::WORD_W-1:0] o_result_word;

    bexm_pkg::t_byte             exp_tbl [bexm_pkg::ROM_DEPTH];
    bexm_pkg::t_byte             log_tbl [bexm_pkg::ROM_DEPTH];
    t_mix_item                   pending_items [$];
    logic [bexm_pkg::WORD_W-1:0] expected_words [$];
    int                          sender_idle_pct = 0;
    int                          error_count = 0;

    byte_exp_xor_mix_core #(
        .LANES (NUM_LANES)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_action      (i_action),
        .i_operand_x   (i_operand_x),
        .i_operand_c   (i_operand_c),
        .o_valid       (o_valid),
        .o_result_word (o_result_word)
    );

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // power sequence of the generator, 256 folded to zero
    initial begin
        int v;
        v = 1;
        for (int i = 0; i < bexm_pkg::ROM_DEPTH; i++) begin
            exp_tbl[i] = (v == WRAP_VALUE) ? bexm_pkg::t_byte'(0) : bexm_pkg::t_byte'(v);
            log_tbl[(v == WRAP_VALUE) ? 0 : v] = bexm_pkg::t_byte'(i);
            v = (v * GEN_BASE) % GEN_MOD;
        end
    end

    function automatic logic [bexm_pkg::WORD_W-1:0] mix_predict(
        logic action, logic [bexm_pkg::WORD_W-1:0] x, logic [bexm_pkg::WORD_W-1:0] c);
        logic [bexm_pkg::WORD_W-1:0] acc;
        bexm_pkg::t_byte             xb;
        bexm_pkg::t_byte             cb;
        bexm_pkg::t_byte             r;
        acc = '0;
        for (int k = 0; k < NUM_LANES; k++) begin
            xb = x[k*bexm_pkg::BYTE_W +: bexm_pkg::BYTE_W];
            cb = c[k*bexm_pkg::BYTE_W +: bexm_pkg::BYTE_W];
            if (action == ACT_INV) begin
                r = log_tbl[xb ^ exp_tbl[cb]];
            end else begin
                r = exp_tbl[xb] ^ exp_tbl[cb];
            end
            acc[k*bexm_pkg::BYTE_W +: bexm_pkg::BYTE_W] = r;
        end
        return acc;
    endfunction

    // bytes lean toward the table corner values now and then
    function automatic logic [bexm_pkg::WORD_W-1:0] rand_word();
        logic [bexm_pkg::WORD_W-1:0] w;
        int                          pick;
        w = {$urandom, $urandom};
        for (int k = 0; k < bexm_pkg::MAX_LANES; k++) begin
            pick = $urandom_range(15);
            case (pick)
                0: w[k*bexm_pkg::BYTE_W +: bexm_pkg::BYTE_W] = 8'h00;
                1: w[k*bexm_pkg::BYTE_W +: bexm_pkg::BYTE_W] = 8'h80;
                2: w[k*bexm_pkg::BYTE_W +: bexm_pkg::BYTE_W] = 8'hFF;
                3: w[k*bexm_pkg::BYTE_W +: bexm_pkg::BYTE_W] = 8'h01;
                default: ;
            endcase
        end
        return w;
    endfunction

    task automatic queue_item(logic action, logic [bexm_pkg::WORD_W-1:0] x,
                              logic [bexm_pkg::WORD_W-1:0] c);
        t_mix_item it;
        it.action = action;
        it.x      = x;
        it.c      = c;
        pending_items.push_back(it);
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || start || expected_words.size() != 0)
            @(negedge i_clk);
    endtask

    // driver: hold an item while busy, otherwise advance or idle
    always @(posedge i_clk) begin
        t_mix_item it;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && busy) begin
            start <= 1'b1;
        end else begin
            if (start) begin
                expected_words.push_back(mix_predict(i_action, i_operand_x, i_operand_c));
            end
            if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                it = pending_items.pop_front();
                start       <= 1'b1;
                i_action    <= it.action;
                i_operand_x <= it.x;
                i_operand_c <= it.c;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: every strobe consumes the oldest expected word
    always @(posedge i_clk) begin
        logic [bexm_pkg::WORD_W-1:0] want;
        if (i_rst_n && o_valid) begin
            if (expected_words.size() == 0) begin
                $error("result_word unexpected: expected none, actual %h", o_result_word);
                error_count++;
            end else begin
                want = expected_words.pop_front();
                if (o_result_word !== want) begin
                    $error("result_word mismatch: expected %h, actual %h",
                           want, o_result_word);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #5ms;
        $display("byte_exp_xor_mix_core regression: fail");
        $finish;
    end

    initial begin
        int                          phase_pct [4];
        logic [bexm_pkg::WORD_W-1:0] x;
        logic [bexm_pkg::WORD_W-1:0] c;
        int                          n;
        int                          pick;
        phase_pct = '{0, 74, 0, 16};
        @(posedge i_rst_n);
        @(negedge i_clk);

        // directed: field extremes and the zero/128 table corners
        queue_item(ACT_FWD, '0, '0);
        queue_item(ACT_FWD, '1, '1);
        queue_item(ACT_INV, '0, '0);
        queue_item(ACT_INV, '1, '1);
        queue_item(ACT_FWD, '1, '0);
        queue_item(ACT_INV, '0, '1);
        queue_item(ACT_FWD, 64'h8080_8080_8080_8080, '0);
        queue_item(ACT_FWD, '0, 64'h8080_8080_8080_8080);
        queue_item(ACT_FWD, 64'h8080_8080_8080_8080, 64'h8080_8080_8080_8080);
        queue_item(ACT_INV, 64'h0101_0101_0101_0101, '0);
        queue_item(ACT_INV, '0, 64'h8080_8080_8080_8080);
        queue_item(ACT_INV, 64'h8080_8080_8080_8080, 64'h8080_8080_8080_8080);
        queue_item(ACT_FWD, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
        queue_item(ACT_INV, mix_predict(ACT_FWD, 64'h0123_4567_89AB_CDEF,
                                        64'hFEDC_BA98_7654_3210), 64'hFEDC_BA98_7654_3210);
        queue_item(ACT_FWD, 64'h00FF_807F_0180_FF00, 64'h8001_FF00_7F80_0102);
        queue_item(ACT_INV, 64'h00FF_807F_0180_FF00, 64'h8001_FF00_7F80_0102);
        queue_item(ACT_FWD, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
        queue_item(ACT_INV, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            sender_idle_pct = phase_pct[p];
            n = 0;
            while (n < PHASE_ITEMS) begin
                x    = rand_word();
                c    = rand_word();
                pick = $urandom_range(99);
                if (pick < 40) begin
                    queue_item(ACT_FWD, x, c);
                    n++;
                end else if (pick < 75) begin
                    // round trip: mix, then recover with the same key
                    queue_item(ACT_FWD, x, c);
                    queue_item(ACT_INV, mix_predict(ACT_FWD, x, c), c);
                    n += 2;
                end else begin
                    queue_item(ACT_INV, x, c);
                    n++;
                end
            end
            // hold the sender until every result of the phase is back
            wait_drained();
        end

        repeat (PIPE_LAT + 6) @(negedge i_clk);
        if (expected_words.size() != 0) begin
            $error("result_word missing: expected %0d more, actual 0", expected_words.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("byte_exp_xor_mix_core regression: pass");
        end else begin
            $display("byte_exp_xor_mix_core regression: fail");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/bexm_pkg.sv
rtl/bexm_lane.sv
rtl/bexm_merge.sv
rtl/byte_exp_xor_mix_core.sv
tb/sv/tb_top.sv
